[hw/rtl/plwt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plwt_pkg
// Shared widths, defaults and helpers for the packet loss window tracker.
// ----------------------------------------------------------------------------
package plwt_pkg;

    localparam int IDX_W           = 8;           // sequence index width
    localparam int CNT_W           = 8;           // carried count width
    localparam int LOST_W          = 9;           // lost total width
    localparam int NUM_IDX         = 1 << IDX_W;  // distinct sequence indices
    localparam int DEF_WINDOW_SIZE = 256;
    localparam int BYTE_W          = 8;           // bits per first-level count
    localparam int BYTE_CNT_W      = 4;           // holds 0..8
    localparam int GRP_BYTES       = 8;           // byte counts per group sum
    localparam int GRP_CNT_W       = 7;           // holds 0..64

    // Count set bits of one byte.
    function automatic logic [BYTE_CNT_W-1:0] popcount8(input logic [BYTE_W-1:0] b);
        logic [BYTE_CNT_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < BYTE_W; k++) begin
            acc = acc + BYTE_CNT_W'(b[k]);
        end
        return acc;
    endfunction

endpackage

[hw/rtl/packet_loss_window_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_loss_window_tracker
// Sequence-number loss bitmap with a running count of lost indices.
// ----------------------------------------------------------------------------
// Each input beat names the previous and current sequence index and the count
// carried by the current packet. The indices from the previous up to, but not
// including, the current one (8-bit wrap) are marked received while the
// previously carried count lasts and lost after it, all in one map update by a
// compare per index; the result beat gives the number of lost entries in the
// window. One beat is taken every cycle unless o_stall is high; each result
// passes the input register, the map update, then a three-stage population
// count, and is held only while the output is stalled. Reset clears the map
// and the carried count.
module packet_loss_window_tracker import plwt_pkg::*; #(
    parameter int WINDOW_SIZE = DEF_WINDOW_SIZE
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [IDX_W-1:0]  i_prev_index,
    input  logic [IDX_W-1:0]  i_curr_index,
    input  logic [CNT_W-1:0]  i_curr_count,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [LOST_W-1:0] o_lost_total
);

    logic                   r_in_v;
    logic [IDX_W-1:0]       r_prev;
    logic [IDX_W-1:0]       r_curr;
    logic [CNT_W-1:0]       r_cnt;
    logic                   w_in_take;
    logic                   w_in_adv;
    logic                   w_pc_ready;
    logic [WINDOW_SIZE-1:0] w_map;

    assign w_in_adv  = r_in_v & w_pc_ready;
    assign o_stall   = r_in_v & ~w_in_adv;
    assign w_in_take = i_valid & ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else begin
            r_in_v <= w_in_take | (r_in_v & ~w_in_adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_prev <= i_prev_index;
            r_curr <= i_curr_index;
            r_cnt  <= i_curr_count;
        end
    end

    plwt_map #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_map (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_update     (w_in_adv),
        .i_prev_index (r_prev),
        .i_curr_index (r_curr),
        .i_curr_count (r_cnt),
        .o_map        (w_map)
    );

    plwt_popcnt #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_popcnt (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_in_adv),
        .o_ready      (w_pc_ready),
        .i_map        (w_map),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_lost_total (o_lost_total)
    );

endmodule

[hw/rtl/plwt_map.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plwt_map
// Loss map and carried count. Applies one combinational walk per update.
// ----------------------------------------------------------------------------
module plwt_map import plwt_pkg::*; #(
    parameter int WINDOW_SIZE = DEF_WINDOW_SIZE
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_update,
    input  logic [IDX_W-1:0]       i_prev_index,
    input  logic [IDX_W-1:0]       i_curr_index,
    input  logic [CNT_W-1:0]       i_curr_count,
    output logic [WINDOW_SIZE-1:0] o_map
);

    logic [WINDOW_SIZE-1:0] r_map;
    logic [WINDOW_SIZE-1:0] n_map;
    logic [CNT_W-1:0]       r_carry;

    logic [IDX_W-1:0]       w_span;
    logic [IDX_W-1:0]       w_off [NUM_IDX];
    logic [NUM_IDX-1:0]     w_idx_seen;
    logic [NUM_IDX-1:0]     w_idx_lost;
    logic [WINDOW_SIZE-1:0] w_slot_seen;
    logic [WINDOW_SIZE-1:0] w_slot_lost;

    assign w_span = i_curr_index - i_prev_index;

    // A slot ends up lost if any visit to it lies past the carried count,
    // since the last visit is then past it too; otherwise a visit clears it.
    always_comb begin
        w_slot_seen = '0;
        w_slot_lost = '0;
        for (int i = 0; i < NUM_IDX; i++) begin
            w_off[i]      = IDX_W'(i) - i_prev_index;
            w_idx_seen[i] = (w_off[i] < w_span);
            w_idx_lost[i] = w_idx_seen[i] && (w_off[i] >= r_carry);
            w_slot_seen[i % WINDOW_SIZE] = w_slot_seen[i % WINDOW_SIZE] | w_idx_seen[i];
            w_slot_lost[i % WINDOW_SIZE] = w_slot_lost[i % WINDOW_SIZE] | w_idx_lost[i];
        end
        n_map = w_slot_lost | (r_map & ~w_slot_seen);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map   <= '0;
            r_carry <= '0;
        end else if (i_update) begin
            r_map   <= n_map;
            r_carry <= i_curr_count;
        end
    end

    assign o_map = r_map;

endmodule

[hw/rtl/plwt_popcnt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plwt_popcnt
// Pipelined population count of the loss map with an output register.
// ----------------------------------------------------------------------------
module plwt_popcnt import plwt_pkg::*; #(
    parameter int WINDOW_SIZE = DEF_WINDOW_SIZE
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    output logic                   o_ready,
    input  logic [WINDOW_SIZE-1:0] i_map,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [LOST_W-1:0]      o_lost_total
);

    localparam int NUM_BYTES = (WINDOW_SIZE + BYTE_W - 1) / BYTE_W;
    localparam int NUM_GRP   = (NUM_BYTES + GRP_BYTES - 1) / GRP_BYTES;
    localparam int NUM_SLOTS = NUM_GRP * GRP_BYTES;
    localparam int PAD_W     = NUM_SLOTS * BYTE_W;

    logic                  r_tok_v;
    logic                  r_byte_v;
    logic                  r_grp_v;
    logic                  r_out_v;
    logic                  w_tok_adv;
    logic                  w_byte_adv;
    logic                  w_grp_adv;
    logic                  w_out_adv;

    logic [PAD_W-1:0]      w_pad;
    logic [BYTE_CNT_W-1:0] r_byte [NUM_SLOTS];
    logic [GRP_CNT_W-1:0]  r_grp  [NUM_GRP];
    logic [GRP_CNT_W-1:0]  n_grp  [NUM_GRP];
    logic [LOST_W-1:0]     n_out;
    logic [LOST_W-1:0]     r_out;

    // Stage advances when the next stage is empty or moving on.
    assign w_out_adv  = r_out_v & ~i_stall;
    assign w_grp_adv  = r_grp_v & (~r_out_v | w_out_adv);
    assign w_byte_adv = r_byte_v & (~r_grp_v | w_grp_adv);
    assign w_tok_adv  = r_tok_v & (~r_byte_v | w_byte_adv);
    assign o_ready    = ~r_tok_v | w_tok_adv;

    always_comb begin
        w_pad = '0;
        w_pad[WINDOW_SIZE-1:0] = i_map;
    end

    always_comb begin
        for (int g = 0; g < NUM_GRP; g++) begin
            n_grp[g] = '0;
            for (int b = 0; b < GRP_BYTES; b++) begin
                n_grp[g] = n_grp[g] + GRP_CNT_W'(r_byte[g*GRP_BYTES + b]);
            end
        end
        n_out = '0;
        for (int g = 0; g < NUM_GRP; g++) begin
            n_out = n_out + LOST_W'(r_grp[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_v  <= 1'b0;
            r_byte_v <= 1'b0;
            r_grp_v  <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_tok_v  <= i_push | (r_tok_v & ~w_tok_adv);
            r_byte_v <= w_tok_adv | (r_byte_v & ~w_byte_adv);
            r_grp_v  <= w_byte_adv | (r_grp_v & ~w_grp_adv);
            r_out_v  <= w_grp_adv | (r_out_v & ~w_out_adv);
        end
    end

    // The map holds still while the token waits, so count it on the way out.
    always_ff @(posedge i_clk) begin
        if (w_tok_adv) begin
            for (int s = 0; s < NUM_SLOTS; s++) begin
                r_byte[s] <= popcount8(w_pad[s*BYTE_W +: BYTE_W]);
            end
        end
        if (w_byte_adv) begin
            for (int g = 0; g < NUM_GRP; g++) begin
                r_grp[g] <= n_grp[g];
            end
        end
        if (w_grp_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid      = r_out_v;
    assign o_lost_total = r_out;

endmodule

[hw/rtl/plwt_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plwt_checker
// Port-level checks for the packet loss window tracker.
// ----------------------------------------------------------------------------
module plwt_checker import plwt_pkg::*; #(
    parameter int WINDOW_SIZE = DEF_WINDOW_SIZE
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic [IDX_W-1:0]  i_prev_index,
    input logic [IDX_W-1:0]  i_curr_index,
    input logic [CNT_W-1:0]  i_curr_count,
    input logic              o_valid,
    input logic              i_stall,
    input logic [LOST_W-1:0] o_lost_total
);

    // Hold a stalled input beat.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid
            && $stable({i_prev_index, i_curr_index, i_curr_count}))
        else $error("input beat changed while stalled");

    // Hold a stalled result beat.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_lost_total))
        else $error("result beat changed while stalled");

    // Never report more lost entries than the window has.
    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_lost_total <= LOST_W'(WINDOW_SIZE))
        else $error("lost total exceeds window size");

    // A free-running output lets the whole pipeline drain, so input never stalls.
    a_no_stall_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_stall |-> !o_stall)
        else $error("input stalled while output was free");

    // The input stalls only while a result beat is held by a stalled output.
    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a stalled result");

endmodule

bind packet_loss_window_tracker plwt_checker #(
    .WINDOW_SIZE (WINDOW_SIZE)
) u_plwt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .i_prev_index (i_prev_index),
    .i_curr_index (i_curr_index),
    .i_curr_count (i_curr_count),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_lost_total (o_lost_total)
);
